[rtl/pat_pkg.sv]
package pat_pkg;

    localparam int MAX_PAGES  = 256;
    localparam int MAX_FRAMES = 64;
    localparam int ADDR_BITS  = 20;

    localparam int PAGE_W   = $clog2(MAX_PAGES);
    localparam int FRAME_W  = $clog2(MAX_FRAMES);
    localparam int SHIFT_W  = 4;
    localparam int PCOUNT_W = 9;
    localparam int FCOUNT_W = 7;
    localparam int MAX_SHIFT = 12;
    localparam int OFF_W    = MAX_SHIFT;
    localparam int CNT_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [SHIFT_W-1:0]  SHIFT_RESET  = SHIFT_W'(8);
    localparam logic [PCOUNT_W-1:0] PCOUNT_RESET = PCOUNT_W'(256);
    localparam logic [FCOUNT_W-1:0] FCOUNT_RESET = FCOUNT_W'(64);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAGE_SHIFT  = 2'd0,
        CFG_PAGE_COUNT  = 2'd1,
        CFG_FRAME_COUNT = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_HIT     = 2'd0,
        ST_FREE    = 2'd1,
        ST_EVICT   = 2'd2,
        ST_INVALID = 2'd3
    } status_t;

    // Configuration after clamping to the legal ranges.
    typedef struct packed {
        logic [SHIFT_W-1:0]  shift;
        logic [PCOUNT_W-1:0] pages;
        logic [FCOUNT_W-1:0] frames;
    } cfg_t;

endpackage

[rtl/pat_ram.sv]
module pat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read data holds until the next read enable.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[rtl/pat_cfg.sv]
module pat_cfg
    import pat_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    logic [SHIFT_W-1:0]  shift_reg,  shift_next;
    logic [PCOUNT_W-1:0] pcount_reg, pcount_next;
    logic [FCOUNT_W-1:0] fcount_reg, fcount_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        shift_next  = shift_reg;
        pcount_next = pcount_reg;
        fcount_next = fcount_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_PAGE_SHIFT:  shift_next  = cfg_data[SHIFT_W-1:0];
                CFG_PAGE_COUNT:  pcount_next = cfg_data[PCOUNT_W-1:0];
                CFG_FRAME_COUNT: fcount_next = cfg_data[FCOUNT_W-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg  <= SHIFT_RESET;
            pcount_reg <= PCOUNT_RESET;
            fcount_reg <= FCOUNT_RESET;
        end
        else
        begin
            shift_reg  <= shift_next;
            pcount_reg <= pcount_next;
            fcount_reg <= fcount_next;
        end
    end

    always_comb
    begin
        cfg.shift  = (shift_reg > SHIFT_W'(MAX_SHIFT)) ? SHIFT_W'(MAX_SHIFT) : shift_reg;
        cfg.pages  = (pcount_reg > PCOUNT_W'(MAX_PAGES)) ? PCOUNT_W'(MAX_PAGES) : pcount_reg;
        if (fcount_reg == '0)
        begin
            cfg.frames = FCOUNT_W'(1);
        end
        else if (fcount_reg > FCOUNT_W'(MAX_FRAMES))
        begin
            cfg.frames = FCOUNT_W'(MAX_FRAMES);
        end
        else
        begin
            cfg.frames = fcount_reg;
        end
    end

endmodule

[rtl/fifo_paged_address_translator.sv]
// Each accepted item first reads its page entry and ring slot from the memories;
// the decision and write-back follow once the output register is free or being
// read, and only then is a new item taken. An item may be accepted while the
// previous result still waits on the output.
// Reset clears the page valid bits, the ring pointers, the totals and restores
// the default configuration; the memories themselves need no clearing pass.
module fifo_paged_address_translator
    import pat_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [23:0]           s_axis_tdata,  // virtual_address[19:0], zero pad
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // status[1:0], physical_address[21:2], frame_used[27:22], evicted_page[35:28],
    // hit_total[67:36], fault_total[99:68], zero pad
    output logic [103:0]          m_axis_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t cfg;

    logic                 busy_reg, busy_next;
    logic [PAGE_W-1:0]    page_reg;
    logic [OFF_W-1:0]     off_reg;
    logic                 inval_reg;
    logic                 resident_reg;
    logic [MAX_PAGES-1:0] valid_reg, valid_next;
    logic [FRAME_W-1:0]   head_reg, head_next;
    logic [FCOUNT_W-1:0]  filled_reg, filled_next;
    logic [CNT_W-1:0]     hits_reg, hits_next;
    logic [CNT_W-1:0]     faults_reg, faults_next;

    logic                 out_valid_reg, out_valid_next;
    status_t              out_status_reg, status_c;
    logic [ADDR_BITS-1:0] out_pa_reg, pa_c;
    logic [FRAME_W-1:0]   out_frame_reg, frame_c;
    logic [PAGE_W-1:0]    out_evict_reg, evict_c;

    logic                 in_acc;
    logic                 finish;
    logic [ADDR_BITS-1:0] va;
    logic [ADDR_BITS-1:0] page_full;
    logic [OFF_W-1:0]     off_c;

    logic                 pf_wr_en;
    logic [FRAME_W-1:0]   pf_rdata;
    logic                 ring_wr_en;
    logic [FRAME_W-1:0]   ring_wr_addr;
    logic [PAGE_W-1:0]    ring_rdata;

    pat_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Page number to frame.
    pat_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (MAX_PAGES)
    ) u_page_frame (
        .clk     (clk),
        .wr_en   (pf_wr_en),
        .wr_addr (page_reg),
        .wr_data (frame_c),
        .rd_en   (in_acc),
        .rd_addr (page_full[PAGE_W-1:0]),
        .rd_data (pf_rdata)
    );

    // Load order ring; slot s always owns frame s.
    pat_ram #(
        .WIDTH (PAGE_W),
        .DEPTH (MAX_FRAMES)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ring_wr_en),
        .wr_addr (ring_wr_addr),
        .wr_data (page_reg),
        .rd_en   (in_acc),
        .rd_addr (head_reg),
        .rd_data (ring_rdata)
    );

    assign s_axis_tready = !busy_reg;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign finish        = busy_reg && (!out_valid_reg || m_axis_tready);

    assign va        = s_axis_tdata[ADDR_BITS-1:0];
    assign page_full = va >> cfg.shift;
    assign off_c     = va[OFF_W-1:0] & ~({OFF_W{1'b1}} << cfg.shift);

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            page_reg     <= page_full[PAGE_W-1:0];
            off_reg      <= off_c;
            inval_reg    <= page_full >= ADDR_BITS'(cfg.pages);
            resident_reg <= valid_reg[page_full[PAGE_W-1:0]];
        end
    end

    always_comb
    begin
        status_c     = ST_INVALID;
        frame_c      = '0;
        evict_c      = '0;
        pf_wr_en     = 1'b0;
        ring_wr_en   = 1'b0;
        ring_wr_addr = head_reg;
        valid_next   = valid_reg;
        head_next    = head_reg;
        filled_next  = filled_reg;
        hits_next    = hits_reg;
        faults_next  = faults_reg;
        busy_next    = busy_reg;

        if (!inval_reg)
        begin
            if (resident_reg)
            begin
                status_c = ST_HIT;
                frame_c  = pf_rdata;
            end
            else if (filled_reg < cfg.frames)
            begin
                status_c     = ST_FREE;
                frame_c      = filled_reg[FRAME_W-1:0];
                ring_wr_addr = filled_reg[FRAME_W-1:0];
            end
            else
            begin
                status_c = ST_EVICT;
                frame_c  = head_reg;
                evict_c  = ring_rdata;
            end
        end

        pa_c = (ADDR_BITS'(frame_c) << cfg.shift) | ADDR_BITS'(off_reg);
        if (status_c == ST_INVALID)
        begin
            pa_c = '0;
        end

        if (finish)
        begin
            busy_next = 1'b0;
            case (status_c) inside
                ST_HIT:
                begin
                    if (hits_reg != '1)
                    begin
                        hits_next = hits_reg + 1'b1;
                    end
                end
                ST_FREE, ST_EVICT:
                begin
                    if (faults_reg != '1)
                    begin
                        faults_next = faults_reg + 1'b1;
                    end
                    pf_wr_en   = 1'b1;
                    ring_wr_en = 1'b1;
                    if (status_c == ST_FREE)
                    begin
                        filled_next = filled_reg + 1'b1;
                    end
                    else
                    begin
                        valid_next[ring_rdata] = 1'b0;
                        head_next = ((FCOUNT_W'(head_reg) + 1'b1) == filled_reg) ?
                                    '0 : head_reg + 1'b1;
                    end
                    valid_next[page_reg] = 1'b1;
                end
                default: ;
            endcase
        end
        if (in_acc)
        begin
            busy_next = 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (m_axis_tvalid && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (finish)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
            head_reg      <= '0;
            filled_reg    <= '0;
            hits_reg      <= '0;
            faults_reg    <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            valid_reg     <= valid_next;
            head_reg      <= head_next;
            filled_reg    <= filled_next;
            hits_reg      <= hits_next;
            faults_reg    <= faults_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            out_status_reg <= status_c;
            out_pa_reg     <= pa_c;
            out_frame_reg  <= frame_c;
            out_evict_reg  <= evict_c;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0, faults_reg, hits_reg, out_evict_reg, out_frame_reg,
                            out_pa_reg, out_status_reg};

    assert property (@(posedge clk) disable iff (!rst_n)
        filled_reg <= FCOUNT_W'(MAX_FRAMES))
        else $error("more frames handed out than exist");

    assert property (@(posedge clk) disable iff (!rst_n)
        (filled_reg == '0) |-> (head_reg == '0))
        else $error("ring head moved before any frame was loaded");

    assert property (@(posedge clk) disable iff (!rst_n)
        (filled_reg != '0) |-> (FCOUNT_W'(head_reg) < filled_reg))
        else $error("ring head points beyond the loaded slots");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(busy_reg))
        else $error("result presented without an item in flight");

    assert property (@(posedge clk) disable iff (!rst_n)
        (finish && status_c == ST_EVICT) |-> valid_reg[ring_rdata])
        else $error("evicting a page that is not resident");

endmodule

[tb/fifo_paged_address_translator_checker.sv]
module fifo_paged_address_translator_checker
    import pat_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [23:0]           s_axis_tdata,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [103:0]          m_axis_tdata,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    error_count,
    output int                    outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        status_t                status;
        logic [ADDR_BITS-1:0]   phys_addr;
        logic [FRAME_W-1:0]     frame;
        logic [PAGE_W-1:0]      evicted;
        logic [CNT_W-1:0]       hits;
        logic [CNT_W-1:0]       faults;
    } translation_t;

    translation_t         pending_translations[$];

    logic                 page_loaded [MAX_PAGES];
    logic [FRAME_W-1:0]   page_frame_no [MAX_PAGES];
    logic [PAGE_W-1:0]    load_ring [MAX_FRAMES];
    logic [FRAME_W-1:0]   oldest_slot;
    logic [FCOUNT_W-1:0]  frames_handed;
    logic [CNT_W-1:0]     hit_total;
    logic [CNT_W-1:0]     fault_total;

    logic [SHIFT_W-1:0]   cfg_shift;
    logic [PCOUNT_W-1:0]  cfg_pages;
    logic [FCOUNT_W-1:0]  cfg_frames;

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    task automatic translate_address(input logic [ADDR_BITS-1:0] va);
        int                   sh;
        int                   pages;
        int                   frames;
        logic [FRAME_W-1:0]   slot;
        logic [ADDR_BITS-1:0] page_no;
        logic [ADDR_BITS-1:0] offset;
        logic [PAGE_W-1:0]    pg;
        logic [PAGE_W-1:0]    victim;
        logic [FRAME_W-1:0]   fr;
        translation_t         r;

        sh     = (cfg_shift > MAX_SHIFT) ? MAX_SHIFT : int'(cfg_shift);
        pages  = (cfg_pages > MAX_PAGES) ? MAX_PAGES : int'(cfg_pages);
        frames = (cfg_frames == 0) ? 1 : int'(cfg_frames);
        if (frames > MAX_FRAMES)
            frames = MAX_FRAMES;

        page_no = va >> sh;
        offset  = va & ADDR_BITS'((1 << sh) - 1);
        r        = '0;
        r.status = ST_INVALID;

        if (page_no < pages)
        begin
            pg = page_no[PAGE_W-1:0];
            if (page_loaded[pg])
            begin
                r.status  = ST_HIT;
                fr        = page_frame_no[pg];
                hit_total = bump(hit_total);
            end
            else
            begin
                fault_total = bump(fault_total);
                if (int'(frames_handed) < frames && frames_handed < MAX_FRAMES)
                begin
                    r.status                                = ST_FREE;
                    fr                                      = frames_handed[FRAME_W-1:0];
                    load_ring[frames_handed[FRAME_W-1:0]]   = pg;
                    frames_handed                           = frames_handed + 1'b1;
                end
                else
                begin
                    // The ring only cycles over the slots already handed out, even
                    // when the frame count has since been lowered.
                    slot                = FRAME_W'(int'(oldest_slot) % int'(frames_handed));
                    victim              = load_ring[slot];
                    r.status            = ST_EVICT;
                    r.evicted           = victim;
                    fr                  = page_frame_no[victim];
                    page_loaded[victim] = 1'b0;
                    load_ring[slot]     = pg;
                    oldest_slot         = FRAME_W'((int'(slot) + 1) % int'(frames_handed));
                end
                page_loaded[pg]   = 1'b1;
                page_frame_no[pg] = fr;
            end
            r.frame     = fr;
            r.phys_addr = ADDR_BITS'((int'(fr) << sh) + int'(offset));
        end
        r.hits   = hit_total;
        r.faults = fault_total;
        pending_translations.push_back(r);
    endtask

    function automatic void check_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            error_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        translation_t want;
        translation_t got;

        if (!rst_n)
        begin
            for (int i = 0; i < MAX_PAGES; i++)
            begin
                page_loaded[i]   = 1'b0;
                page_frame_no[i] = '0;
            end
            for (int i = 0; i < MAX_FRAMES; i++)
                load_ring[i] = '0;
            oldest_slot   = '0;
            frames_handed = '0;
            hit_total     = '0;
            fault_total   = '0;
            cfg_shift     = SHIFT_RESET;
            cfg_pages     = PCOUNT_RESET;
            cfg_frames    = FCOUNT_RESET;
            pending_translations.delete();
            error_count   = 0;
            outstanding   = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_PAGE_SHIFT:  cfg_shift  = cfg_data[SHIFT_W-1:0];
                    CFG_PAGE_COUNT:  cfg_pages  = cfg_data[PCOUNT_W-1:0];
                    CFG_FRAME_COUNT: cfg_frames = cfg_data[FCOUNT_W-1:0];
                    default: ;
                endcase
            end

            // A result leaves no earlier than the cycle after its input, so the
            // output side is checked before this cycle's input joins the queue.
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = translation_t'({status_t'(m_axis_tdata[1:0]), m_axis_tdata[21:2],
                                      m_axis_tdata[27:22], m_axis_tdata[35:28],
                                      m_axis_tdata[67:36], m_axis_tdata[99:68]});
                if (pending_translations.size() == 0)
                begin
                    $error("result transaction with no translation pending");
                    error_count++;
                end
                else
                begin
                    want = pending_translations.pop_front();
                    check_field("status", 32'(want.status), 32'(got.status));
                    check_field("physical_address", 32'(want.phys_addr), 32'(got.phys_addr));
                    check_field("frame_used", 32'(want.frame), 32'(got.frame));
                    check_field("evicted_page", 32'(want.evicted), 32'(got.evicted));
                    check_field("hit_total", want.hits, got.hits);
                    check_field("fault_total", want.faults, got.faults);
                end
            end

            if (s_axis_tvalid && s_axis_tready)
                translate_address(s_axis_tdata[ADDR_BITS-1:0]);

            outstanding = pending_translations.size();
        end
    end

endmodule

[tb/fifo_paged_address_translator_tb.sv]
module fifo_paged_address_translator_tb
    import pat_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 14;

    // Per phase: page shift, page count, frame count, working set of pages, items.
    localparam int PH_SHIFT [PHASES] = '{0, 3, 12, 13, 5, 6, 8, 1, 15, 10, 7, 2, 9, 11};
    localparam int PH_PAGES [PHASES] = '{16, 64, 256, 200, 511, 1, 40, 256, 128, 256, 100,
                                         3, 256, 300};
    localparam int PH_FRAMES[PHASES] = '{4, 8, 16, 16, 6, 3, 24, 32, 48, 64, 127, 1, 0, 64};
    localparam int PH_WSET  [PHASES] = '{8, 12, 24, 40, 10, 1, 40, 48, 64, 96, 100, 3, 4, 128};
    localparam int PH_ITEMS [PHASES] = '{106, 106, 106, 106, 106, 60, 106, 106, 106, 106, 106,
                                         106, 106, 106};

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [23:0]           s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [103:0]          m_axis_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int error_count;
    int outstanding;
    int cycle_count;
    bit tx_burst;
    bit rx_burst;

    fifo_paged_address_translator i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    fifo_paged_address_translator_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .error_count   (error_count),
        .outstanding   (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("fifo_paged_address_translator_tb: errors");
            $finish;
        end
    end

    // Result side: a random stall before each transaction, with long stretches
    // of no stalling at all.
    initial
    begin
        int stall;

        m_axis_tready = 1'b0;
        rx_burst      = 1'b0;
        forever
        begin
            if ($urandom_range(0, 63) == 0)
                rx_burst = !rx_burst;
            stall = rx_burst ? 0 : $urandom_range(0, 10);
            @(negedge clk);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    task automatic send_address(input logic [ADDR_BITS-1:0] va);
        int gap;

        gap = tx_burst ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, va};
        do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
    endtask

    // Stops the sender and waits until every translation has come back.
    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
    endtask

    task automatic end_writes();
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input int ph);
        int sh;
        int pages;
        int pg;
        int pick;
        logic [ADDR_BITS-1:0] va;

        drain();
        write_reg(CFG_PAGE_SHIFT, CFG_DATA_W'(PH_SHIFT[ph]));
        write_reg(CFG_PAGE_COUNT, CFG_DATA_W'(PH_PAGES[ph]));
        write_reg(CFG_FRAME_COUNT, CFG_DATA_W'(PH_FRAMES[ph]));
        end_writes();

        sh       = (PH_SHIFT[ph] > MAX_SHIFT) ? MAX_SHIFT : PH_SHIFT[ph];
        pages    = (PH_PAGES[ph] > MAX_PAGES) ? MAX_PAGES : PH_PAGES[ph];
        tx_burst = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < PH_ITEMS[ph]; i++)
        begin
            pick = $urandom_range(0, 15);
            if (pick < 2)
                va = ADDR_BITS'($urandom);
            else
            begin
                // Mostly pages of the working set, now and then one just out of range.
                if (pick == 2)
                    pg = pages + $urandom_range(0, 3);
                else
                    pg = $urandom_range(0, PH_WSET[ph] - 1);
                va = ADDR_BITS'((pg << sh) | ($urandom & ((1 << sh) - 1)));
            end
            send_address(va);
            if (i == PH_ITEMS[ph] / 2 && (ph == 3 || $urandom_range(0, 7) == 0))
                drain();
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_PAGE_SHIFT;
        cfg_data      = '0;
        cycle_count   = 0;
        tx_burst      = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // Small pages, eight of them, two frames: free frames, hits, evictions,
        // the largest offset and addresses past the page count.
        write_reg(CFG_PAGE_SHIFT, 9'd4);
        write_reg(CFG_PAGE_COUNT, 9'd8);
        write_reg(CFG_FRAME_COUNT, 9'd2);
        end_writes();
        send_address(20'h00000);
        send_address(20'h0000F);
        send_address(20'h00010);
        send_address(20'h00025);
        send_address(20'h00003);
        send_address(20'h0001A);
        send_address(20'h0007F);
        send_address(20'h00080);
        send_address(20'hFFFFF);
        send_address(20'h0007F);

        // Shift beyond the maximum, no pages at all, and a write to an unused index.
        drain();
        write_reg(CFG_PAGE_SHIFT, 9'd15);
        write_reg(CFG_PAGE_COUNT, 9'd0);
        write_reg(CFG_UNUSED, 9'h1FF);
        end_writes();
        send_address(20'h00000);
        send_address(20'h12345);

        // Page count above the maximum, frame count of zero with two frames loaded.
        drain();
        write_reg(CFG_PAGE_COUNT, 9'h1FF);
        write_reg(CFG_FRAME_COUNT, 9'd0);
        end_writes();
        send_address(20'hFF000);
        send_address(20'hFFFFF);
        send_address(20'h00FFF);
        send_address(20'h00000);

        // Byte pages, frame count above the maximum after the ring has wrapped.
        drain();
        write_reg(CFG_PAGE_SHIFT, 9'd0);
        write_reg(CFG_PAGE_COUNT, 9'd256);
        write_reg(CFG_FRAME_COUNT, 9'd127);
        end_writes();
        send_address(20'h000FF);
        send_address(20'h00000);
        send_address(20'h00001);
        send_address(20'h000FF);
        send_address(20'h00100);

        for (int ph = 0; ph < PHASES; ph++)
            run_phase(ph);

        drain();
        repeat (6) @(negedge clk);
        if (error_count == 0)
            $display("fifo_paged_address_translator_tb: clean");
        else
            $display("fifo_paged_address_translator_tb: errors");
        $finish;
    end

endmodule
